// ===== design/tdfp_pkg.sv =====
`timescale 1ns / 1ps
package tdfp_pkg;

  // default frame length in bytes
  localparam int FRAME_LEN_DEF = 6;

  // sensor tags
  localparam logic [1:0] TAG_AFT  = 2'd0;
  localparam logic [1:0] TAG_MID  = 2'd1;
  localparam logic [1:0] TAG_FORE = 2'd2;

  // a distance is kept only above this value
  localparam logic [7:0] MIN_VALID = 8'd5;

  // pair limit per frame
  localparam logic [1:0] MAX_PAIRS = 2'd3;

  // reset value of the clamp register
  localparam logic [7:0] MAX_DIST_RST = 8'd255;

endpackage

// ===== design/tagged_distance_frame_parser.sv =====
`timescale 1ns / 1ps
// channel  | ports                                        | direction
// ---------+----------------------------------------------+----------
// input    | in_valid, in_ready, in_rx_byte               | in
// result   | out_valid, out_ready, out_aft_distance,      | out
//          | out_mid_distance, out_fore_distance,         |
//          | out_pairs_found                              |
// config   | cfg_wr_en, cfg_wr_data (max_distance)        | in
//
// One byte is taken per cycle; the frame state is updated in the cycle of the
// request, and the last byte of a frame loads the result register, so a result
// appears in the cycle after that byte. Synchronous active-low reset clears the
// frame state, held distances and sets the clamp to 255. While a result waits
// unread, bytes that do not end a frame are still taken; a frame-ending byte
// waits until the result register is free or being read.
module tagged_distance_frame_parser #(
  parameter int FRAME_LEN = tdfp_pkg::FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_aft_distance,
  output logic [7:0] out_mid_distance,
  output logic [7:0] out_fore_distance,
  output logic [1:0] out_pairs_found,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import tdfp_pkg::*;

  localparam int POS_W = (FRAME_LEN > 2) ? $clog2(FRAME_LEN) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  logic [7:0]       max_dist_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             expect_r, expect_nxt;
  logic [1:0]       tag_r, tag_nxt;
  logic [1:0]       pairs_r, pairs_nxt;
  logic [7:0]       aft_r, aft_nxt;
  logic [7:0]       mid_r, mid_nxt;
  logic [7:0]       fore_r, fore_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_aft_r, out_mid_r, out_fore_r;
  logic [1:0]       out_pairs_r;

  logic       last;
  logic       accept;
  logic [7:0] clamped;
  logic       is_tag;

  assign last    = (pos_r == LAST_POS);
  assign in_ready = !out_valid_r || out_ready || !last;
  assign accept  = in_valid && in_ready;
  assign clamped = (in_rx_byte > max_dist_r) ? max_dist_r : in_rx_byte;
  assign is_tag  = (in_rx_byte <= {6'd0, TAG_FORE}) && (pairs_r < MAX_PAIRS) && !last;

  // frame scan and distance store
  always_comb begin
    pos_nxt    = pos_r;
    expect_nxt = expect_r;
    tag_nxt    = tag_r;
    pairs_nxt  = pairs_r;
    aft_nxt    = aft_r;
    mid_nxt    = mid_r;
    fore_nxt   = fore_r;
    if (accept) begin
      if (expect_r) begin
        expect_nxt = 1'b0;
        if (clamped > MIN_VALID) begin
          case (tag_r)
            TAG_AFT:  aft_nxt  = clamped;
            TAG_MID:  mid_nxt  = clamped;
            TAG_FORE: fore_nxt = clamped;
            default:  ;
          endcase
        end
      end else if (is_tag) begin
        tag_nxt    = in_rx_byte[1:0];
        expect_nxt = 1'b1;
        pairs_nxt  = pairs_r + 2'd1;
      end
      if (last) begin
        pos_nxt    = '0;
        expect_nxt = 1'b0;
        tag_nxt    = TAG_AFT;
        pairs_nxt  = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && last) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r  <= MAX_DIST_RST;
      pos_r       <= '0;
      expect_r    <= 1'b0;
      tag_r       <= TAG_AFT;
      pairs_r     <= '0;
      aft_r       <= '0;
      mid_r       <= '0;
      fore_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_dist_r <= cfg_wr_data;
      end
      pos_r       <= pos_nxt;
      expect_r    <= expect_nxt;
      tag_r       <= tag_nxt;
      pairs_r     <= pairs_nxt;
      aft_r       <= aft_nxt;
      mid_r       <= mid_nxt;
      fore_r      <= fore_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && last) begin
      out_aft_r   <= aft_nxt;
      out_mid_r   <= mid_nxt;
      out_fore_r  <= fore_nxt;
      out_pairs_r <= pairs_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_aft_distance  = out_aft_r;
  assign out_mid_distance  = out_mid_r;
  assign out_fore_distance = out_fore_r;
  assign out_pairs_found   = out_pairs_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import tdfp_pkg::*;

  localparam int FRAME_LEN = FRAME_LEN_DEF;
  localparam int PHASES = 6;
  localparam int RANDOM_FRAMES = 27;

  typedef struct {
    logic [7:0] aft;
    logic [7:0] mid;
    logic [7:0] fore;
    logic [1:0] pairs;
  } frame_report_t;

  // directed frames: full pairs, distances that look like tags, tag in the last slot
  localparam logic [7:0] DIRECTED_FRAMES [3][FRAME_LEN] = '{
    '{8'(TAG_AFT), 8'd255, 8'(TAG_MID), 8'd6, 8'(TAG_FORE), 8'd200},
    '{8'(TAG_AFT), 8'(TAG_FORE), 8'(TAG_MID), 8'(TAG_AFT), 8'(TAG_FORE), MIN_VALID},
    '{8'd9, 8'd255, 8'd128, 8'd3, 8'd77, 8'(TAG_MID)}
  };

  // clamp setting and idle rates per phase
  localparam logic [7:0] PHASE_CLAMP [PHASES] = '{8'd255, 8'd5, 8'd0, 8'd137, 8'd6, 8'd255};
  localparam int PHASE_SEND_IDLE [PHASES] = '{0, 67, 0, 18, 67, 0};
  localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 67, 18, 67, 67};

  logic [1:0] sensor_tags [3] = '{TAG_AFT, TAG_MID, TAG_FORE};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_aft_distance;
  logic [7:0] out_mid_distance;
  logic [7:0] out_fore_distance;
  logic [1:0] out_pairs_found;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  // pending serial bytes and expected frame reports
  logic [7:0]    rx_feed [$];
  frame_report_t report_queue [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_feed = 1'b0;
  int bytes_taken = 0;
  int reports_checked = 0;
  int error_count = 0;

  // parser model state
  logic [7:0] clamp_limit = MAX_DIST_RST;
  int         rx_frame_pos = 0;
  bit         awaiting_distance = 1'b0;
  logic [1:0] awaited_sensor = TAG_AFT;
  logic [1:0] pairs_in_frame = 2'd0;
  logic [7:0] aft_hold = 8'd0;
  logic [7:0] mid_hold = 8'd0;
  logic [7:0] fore_hold = 8'd0;

  tagged_distance_frame_parser #(
    .FRAME_LEN(FRAME_LEN)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_aft_distance (out_aft_distance),
    .out_mid_distance (out_mid_distance),
    .out_fore_distance(out_fore_distance),
    .out_pairs_found  (out_pairs_found),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // advance the parser model by one received byte
  task automatic parse_rx_byte(input logic [7:0] rx);
    bit         at_last;
    logic [7:0] clamped;
    at_last = (rx_frame_pos >= FRAME_LEN - 1);
    if (awaiting_distance) begin
      clamped = (rx > clamp_limit) ? clamp_limit : rx;
      if (clamped > MIN_VALID) begin
        case (awaited_sensor)
          TAG_AFT: aft_hold = clamped;
          TAG_MID: mid_hold = clamped;
          TAG_FORE: fore_hold = clamped;
          default: ;
        endcase
      end
      awaiting_distance = 1'b0;
    end else if (rx <= 8'(TAG_FORE) && pairs_in_frame < MAX_PAIRS && !at_last) begin
      awaited_sensor = rx[1:0];
      awaiting_distance = 1'b1;
      pairs_in_frame = pairs_in_frame + 2'd1;
    end
    if (at_last) begin
      report_queue.push_back('{aft_hold, mid_hold, fore_hold, pairs_in_frame});
      rx_frame_pos = 0;
      awaiting_distance = 1'b0;
      awaited_sensor = TAG_AFT;
      pairs_in_frame = 2'd0;
    end else begin
      rx_frame_pos++;
    end
  endtask

  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // byte driver: a new request only once the previous one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        parse_rx_byte(in_rx_byte);
        bytes_taken++;
      end
      if (rx_feed.size() != 0 && !hold_feed && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // report monitor with random back-pressure
  always @(posedge clk) begin
    frame_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_queue.size() == 0) begin
          $display("%0t: unexpected report aft %0d mid %0d fore %0d pairs %0d", $time,
                   out_aft_distance, out_mid_distance, out_fore_distance, out_pairs_found);
          error_count++;
        end else begin
          want = report_queue.pop_front();
          report_field("aft_distance", want.aft, out_aft_distance);
          report_field("mid_distance", want.mid, out_mid_distance);
          report_field("fore_distance", want.fore, out_fore_distance);
          report_field("pairs_found", 8'(want.pairs), 8'(out_pairs_found));
          reports_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // phase sequencing
  initial begin
    int pos;
    int phase_start;
    logic [7:0] value;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      // clamp update while the parser is idle
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= PHASE_CLAMP[ph];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      clamp_limit = PHASE_CLAMP[ph];
      sender_idle_pct = PHASE_SEND_IDLE[ph];
      receiver_stall_pct = PHASE_RECV_STALL[ph];
      phase_start = bytes_taken;

      // directed frames: reset clamp first, then the small clamp
      if (ph == 0) begin
        for (int f = 0; f < 3; f++)
          for (int i = 0; i < FRAME_LEN; i++) rx_feed.push_back(DIRECTED_FRAMES[f][i]);
      end else if (ph == 1) begin
        for (int i = 0; i < FRAME_LEN; i++) rx_feed.push_back(DIRECTED_FRAMES[0][i]);
      end

      // random frames, mostly well-formed tag and distance pairs
      for (int f = 0; f < RANDOM_FRAMES; f++) begin
        pos = 0;
        if ($urandom_range(99) < 20) begin
          for (int k = 0; k < FRAME_LEN; k++) rx_feed.push_back(8'($urandom_range(255)));
        end else begin
          while (pos < FRAME_LEN) begin
            if (pos < FRAME_LEN - 1 && $urandom_range(99) < 60) begin
              value = ($urandom_range(1)) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
              rx_feed.push_back(8'(sensor_tags[$urandom_range(2)]));
              rx_feed.push_back(value);
              pos += 2;
            end else begin
              if (pos == FRAME_LEN - 1 && $urandom_range(99) < 30)
                rx_feed.push_back(8'(sensor_tags[$urandom_range(2)]));
              else if ($urandom_range(99) < 70)
                rx_feed.push_back(8'($urandom_range(255, 3)));
              else
                rx_feed.push_back(8'($urandom_range(255)));
              pos++;
            end
          end
        end
      end

      // in phase 3, after 80 bytes, hold the sender until every outstanding report has drained
      if (ph == 3) begin
        wait (bytes_taken >= phase_start + 80);
        hold_feed = 1'b1;
        wait (!in_valid && report_queue.size() == 0);
        repeat (20) @(posedge clk);
        hold_feed = 1'b0;
      end

      wait (rx_feed.size() == 0 && !in_valid && report_queue.size() == 0);
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    $display("sent %0d bytes, checked %0d frame reports over %0d clamp settings",
             bytes_taken, reports_checked, PHASES);
    $display("idle mixes: none, sender only, receiver only, both, with one drain hold");
    if (error_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
